@@ src/pit_pkg.sv @@
// Shared widths, types and codes for the point-in-triangle test block.
package pit_pkg;

    // Coordinate and tolerance formats
    localparam int COORD_BITS = 24;
    localparam int TOL_BITS   = 24;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;

    // Widths that follow from the coordinate width
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    // Limb width of the partial-product multiplier
    localparam int MH_W = ((CROSS_W + 1) / 2 > TOL_BITS / 2) ? (CROSS_W + 1) / 2
                                                             : TOL_BITS / 2;
    localparam int M_W   = 2 * MH_W;
    localparam int WM_W  = 2 * M_W;
    localparam int WP_W  = 2 * WM_W;
    localparam int SUM_W = WM_W + 2;
    localparam int TSQ_W = 2 * TOL_BITS;

    // Register map
    localparam logic [ADDR_W-3:0] REG_TOL = '0;
    localparam logic signed [TOL_BITS-1:0] TOL_RESET = -24'sd168;

    // Failing edge codes
    localparam logic [1:0] FAIL_NONE = 2'd0;
    localparam logic [1:0] FAIL_E0   = 2'd1;
    localparam logic [1:0] FAIL_E1   = 2'd2;
    localparam logic [1:0] FAIL_E2   = 2'd3;

    typedef logic signed [COORD_BITS-1:0] pit_coord_t;
    typedef logic signed [DIFF_W-1:0]     pit_diff_t;
    typedef logic signed [PROD_W-1:0]     pit_prod_t;
    typedef logic signed [CROSS_W-1:0]    pit_cross_t;
    typedef logic [M_W-1:0]               pit_mag_t;

    // Stage enables of one partial-product multiplier
    typedef struct packed {
        logic pp_en;
        logic sum_en;
    } pit_mul_ctl_t;

    // Stage enables of the wide multiplier built from four narrow ones
    typedef struct packed {
        pit_mul_ctl_t part;
        logic         sum_en;
    } pit_wmul_ctl_t;

    // Exact signed product of two coordinate differences
    function automatic pit_prod_t mul_diff(input pit_diff_t a, input pit_diff_t b);
        return pit_prod_t'(a) * pit_prod_t'(b);
    endfunction

    // Magnitude of p1 - p2, zero-extended to the multiplier operand width
    function automatic pit_mag_t cross_mag(input pit_prod_t p1, input pit_prod_t p2);
        pit_cross_t d;
        if (p1 < p2)
        begin
            d = pit_cross_t'(p2) - pit_cross_t'(p1);
        end
        else
        begin
            d = pit_cross_t'(p1) - pit_cross_t'(p2);
        end
        return pit_mag_t'($unsigned(d));
    endfunction

endpackage

@@ src/pit_mul.sv @@
// Two-stage unsigned multiplier built from four limb partial products.
module pit_mul (
    input  logic                        clk,
    input  pit_pkg::pit_mul_ctl_t       ctl,
    input  logic [pit_pkg::M_W-1:0]     a,
    input  logic [pit_pkg::M_W-1:0]     b,
    output logic [pit_pkg::WM_W-1:0]    prod
);

    localparam int H = pit_pkg::MH_W;
    localparam int M = pit_pkg::M_W;

    logic [M-1:0]   ll_next, lh_next, hl_next, hh_next;
    logic [M-1:0]   ll_reg, lh_reg, hl_reg, hh_reg;
    logic [M:0]     mid;
    logic [2*M-1:0] prod_next, prod_reg;

    // Form the limb partial products
    always_comb
    begin
        ll_next = M'(a[H-1:0]) * M'(b[H-1:0]);
        lh_next = M'(a[H-1:0]) * M'(b[M-1:H]);
        hl_next = M'(a[M-1:H]) * M'(b[H-1:0]);
        hh_next = M'(a[M-1:H]) * M'(b[M-1:H]);
    end

    // Combine cross terms and place them between the low and high products
    always_comb
    begin
        mid       = {1'b0, lh_reg} + {1'b0, hl_reg};
        prod_next = {hh_reg, ll_reg} + {{(H-1){1'b0}}, mid, {H{1'b0}}};
    end

    // Advance each stage when the pipeline lets it
    always_ff @(posedge clk)
    begin
        if (ctl.pp_en)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
        end
        if (ctl.sum_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

@@ src/pit_wmul.sv @@
// Three-stage wide unsigned multiplier made of four narrow multipliers.
module pit_wmul (
    input  logic                        clk,
    input  pit_pkg::pit_wmul_ctl_t      ctl,
    input  logic [pit_pkg::WM_W-1:0]    a,
    input  logic [pit_pkg::WM_W-1:0]    b,
    output logic [pit_pkg::WP_W-1:0]    prod
);

    localparam int M = pit_pkg::M_W;
    localparam int W = pit_pkg::WM_W;

    logic [W-1:0]   ll, lh, hl, hh;
    logic [W:0]     mid;
    logic [2*W-1:0] prod_next, prod_reg;

    // Partial products on half-width operands
    pit_mul u_ll (.clk(clk), .ctl(ctl.part), .a(a[M-1:0]), .b(b[M-1:0]), .prod(ll));
    pit_mul u_lh (.clk(clk), .ctl(ctl.part), .a(a[M-1:0]), .b(b[W-1:M]), .prod(lh));
    pit_mul u_hl (.clk(clk), .ctl(ctl.part), .a(a[W-1:M]), .b(b[M-1:0]), .prod(hl));
    pit_mul u_hh (.clk(clk), .ctl(ctl.part), .a(a[W-1:M]), .b(b[W-1:M]), .prod(hh));

    // Sum the partial products into the full-width result
    always_comb
    begin
        mid       = {1'b0, lh} + {1'b0, hl};
        prod_next = {hh, ll} + {{(M-1){1'b0}}, mid, {M{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

@@ src/point_in_triangle_test_top.sv @@
// Top level of the pipelined point-in-triangle edge test.
//
// Takes one request per clock cycle, with no gap between requests, while no output
// stall backs the pipeline up, and presents its results in order: eleven register
// stages, the accepting edge loading the first. The wide products are split
// into limb partial products over two and three stages. Each request carries
// vertices a, b, c and a point, signed Q12.12.
// Each stage carries its own valid bit, so an output stall holds only the
// full stages and empty ones keep taking requests. The edge tolerance register
// (byte address 0, 24-bit signed, units of 2^-24, reset -168) is written over the
// APB port; the user must write it only while no request is in flight, which the block itself does not enforce.
module point_in_triangle_test_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pit_pkg::ADDR_W-1:0]     paddr,
    input  logic [pit_pkg::DATA_W-1:0]     pwdata,
    output logic [pit_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    // Request channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pit_pkg::pit_coord_t            vert_a_x,
    input  pit_pkg::pit_coord_t            vert_a_y,
    input  pit_pkg::pit_coord_t            vert_a_z,
    input  pit_pkg::pit_coord_t            vert_b_x,
    input  pit_pkg::pit_coord_t            vert_b_y,
    input  pit_pkg::pit_coord_t            vert_b_z,
    input  pit_pkg::pit_coord_t            vert_c_x,
    input  pit_pkg::pit_coord_t            vert_c_y,
    input  pit_pkg::pit_coord_t            vert_c_z,
    input  pit_pkg::pit_coord_t            point_x,
    input  pit_pkg::pit_coord_t            point_y,
    input  pit_pkg::pit_coord_t            point_z,
    // Result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           inside_res,
    output logic [1:0]                     failing_edge,
    output logic                           degenerate
);

    localparam int ST_DIFF  = 1;
    localparam int ST_PROD  = 2;
    localparam int ST_CROSS = 3;
    localparam int ST_MPP   = 4;
    localparam int ST_MSUM  = 5;
    localparam int ST_DOT   = 6;
    localparam int ST_SMAG  = 7;
    localparam int ST_WPP   = 8;
    localparam int ST_WMID  = 9;
    localparam int ST_WSUM  = 10;
    localparam int ST_OUT   = 11;
    localparam int NUM_ST   = 11;

    localparam int NXT [3] = '{1, 2, 0};

    localparam int TB   = pit_pkg::TOL_BITS;
    localparam int SW   = pit_pkg::SUM_W;
    localparam int WW   = pit_pkg::WM_W;
    localparam int WP   = pit_pkg::WP_W;
    localparam int TSQ  = pit_pkg::TSQ_W;

    // Per-edge sign facts and degenerate flag that ride beside the wide products
    typedef struct packed {
        logic       degen;
        logic [2:0] s_neg;
        logic [2:0] s_zero;
    } pit_side_t;

    // Pipeline control
    logic [NUM_ST:1] valid_reg, valid_next, stage_en;

    // Configuration
    logic signed [TB-1:0]  tol_reg;
    logic signed [TSQ-1:0] tol_w;
    logic [TSQ-1:0]        tol_sq_next, tol_sq_reg;
    logic                  cfg_wr;

    // Stage 1: differences
    pit_pkg::pit_coord_t coord [4][3];
    pit_pkg::pit_diff_t  e_next [3][3], e_reg [3][3];
    pit_pkg::pit_diff_t  ca_next [3], ca_reg [3];
    pit_pkg::pit_diff_t  d_next [3][3], d_reg [3][3];

    // Stage 2: cross-product terms
    pit_pkg::pit_prod_t  np_next [3][2], np_reg [3][2];
    pit_pkg::pit_prod_t  qp_next [3][3][2], qp_reg [3][3][2];

    // Stage 3: cross-product magnitudes and signs
    pit_pkg::pit_mag_t   nm_next [3], nm_reg [3];
    logic                nn_next [3], nn_reg [3];
    pit_pkg::pit_mag_t   qm_next [3][3], qm_reg [3][3];
    logic                qn_next [3][3], qn_reg [3][3];

    // Stages 4 and 5: narrow products
    pit_pkg::pit_mul_ctl_t mctl;
    logic                tn4_reg [3][3], tn5_reg [3][3];
    logic [WW-1:0]       nsq [3];
    logic [WW-1:0]       qnp [3][3];

    // Stage 6: dot-product sums
    logic [SW-1:0]       n2_next, n2_reg;
    logic [SW-1:0]       ps_next [3], ps_reg [3];
    logic [SW-1:0]       ns_next [3], ns_reg [3];

    // Stage 7: signed dot products as magnitude and sign
    logic [SW-1:0]       pmn [3], nmp [3];
    logic [WW-1:0]       smag_next [3], smag_reg [3];
    logic [WW-1:0]       n2w_next, n2w_reg;
    logic [WW-1:0]       tsq_op;
    pit_side_t           side7_next, side7_reg;

    // Stages 8 to 10: wide products
    pit_pkg::pit_wmul_ctl_t wctl;
    pit_side_t           side8_reg, side9_reg, side10_reg;
    logic [WP-1:0]       s2 [3];
    logic [WP-1:0]       t2;

    // Stage 11: result
    logic [2:0]          bad;
    logic                tol_neg;
    logic                inside_next, inside_reg;
    logic [1:0]          fail_next, fail_reg;
    logic                degen_next, degen_reg;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                 && (paddr[pit_pkg::ADDR_W-1:2] == pit_pkg::REG_TOL);

    always_comb
    begin
        if (paddr[pit_pkg::ADDR_W-1:2] == pit_pkg::REG_TOL)
        begin
            prdata = {{(pit_pkg::DATA_W-TB){1'b0}}, tol_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // Hold the tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= pit_pkg::TOL_RESET;
        end
        else if (cfg_wr)
        begin
            tol_reg <= $signed(pwdata[TB-1:0]);
        end
    end

    // Keep the squared tolerance ready for the threshold product
    always_comb
    begin
        tol_w       = TSQ'(tol_reg);
        tol_sq_next = $unsigned(tol_w * tol_w);
    end

    always_ff @(posedge clk)
    begin
        tol_sq_reg <= tol_sq_next;
    end

    // ---------------------------------------------------------------
    // Pipeline control
    // ---------------------------------------------------------------

    // A stage loads when it is empty or every full stage after it moves
    for (genvar g = 1; g <= NUM_ST; g++)
    begin : g_en
        assign stage_en[g] = out_ready || !(&valid_reg[NUM_ST:g]);
    end

    always_comb
    begin
        for (int k = 1; k <= NUM_ST; k++)
        begin
            if (stage_en[k])
            begin
                valid_next[k] = (k == 1) ? in_valid : valid_reg[k-1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_en[ST_DIFF];
    assign out_valid = valid_reg[ST_OUT];

    // ---------------------------------------------------------------
    // Stage 1: edges, c - a and point offsets
    // ---------------------------------------------------------------

    always_comb
    begin
        coord[0][0] = vert_a_x;
        coord[0][1] = vert_a_y;
        coord[0][2] = vert_a_z;
        coord[1][0] = vert_b_x;
        coord[1][1] = vert_b_y;
        coord[1][2] = vert_b_z;
        coord[2][0] = vert_c_x;
        coord[2][1] = vert_c_y;
        coord[2][2] = vert_c_z;
        coord[3][0] = point_x;
        coord[3][1] = point_y;
        coord[3][2] = point_z;
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e_next[i][k] = pit_pkg::pit_diff_t'(coord[NXT[i]][k])
                             - pit_pkg::pit_diff_t'(coord[i][k]);
                d_next[i][k] = pit_pkg::pit_diff_t'(coord[3][k])
                             - pit_pkg::pit_diff_t'(coord[i][k]);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            ca_next[k] = pit_pkg::pit_diff_t'(coord[2][k]) - pit_pkg::pit_diff_t'(coord[0][k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_DIFF])
        begin
            e_reg  <= e_next;
            d_reg  <= d_next;
            ca_reg <= ca_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: cross-product terms for the normal and each edge
    // ---------------------------------------------------------------

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            np_next[k][0] = pit_pkg::mul_diff(e_reg[0][NXT[k]], ca_reg[NXT[NXT[k]]]);
            np_next[k][1] = pit_pkg::mul_diff(e_reg[0][NXT[NXT[k]]], ca_reg[NXT[k]]);
            for (int i = 0; i < 3; i++)
            begin
                qp_next[i][k][0] = pit_pkg::mul_diff(e_reg[i][NXT[k]],
                                                     d_reg[i][NXT[NXT[k]]]);
                qp_next[i][k][1] = pit_pkg::mul_diff(e_reg[i][NXT[NXT[k]]],
                                                     d_reg[i][NXT[k]]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_PROD])
        begin
            np_reg <= np_next;
            qp_reg <= qp_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: cross products as magnitude and sign
    // ---------------------------------------------------------------

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nm_next[k] = pit_pkg::cross_mag(np_reg[k][0], np_reg[k][1]);
            nn_next[k] = np_reg[k][0] < np_reg[k][1];
            for (int i = 0; i < 3; i++)
            begin
                qm_next[i][k] = pit_pkg::cross_mag(qp_reg[i][k][0], qp_reg[i][k][1]);
                qn_next[i][k] = qp_reg[i][k][0] < qp_reg[i][k][1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_CROSS])
        begin
            nm_reg <= nm_next;
            nn_reg <= nn_next;
            qm_reg <= qm_next;
            qn_reg <= qn_next;
        end
    end

    // ---------------------------------------------------------------
    // Stages 4 and 5: normal squares and edge-normal products
    // ---------------------------------------------------------------

    assign mctl.pp_en  = stage_en[ST_MPP];
    assign mctl.sum_en = stage_en[ST_MSUM];

    for (genvar gk = 0; gk < 3; gk++)
    begin : g_nsq
        pit_mul u_sq (
            .clk  (clk),
            .ctl  (mctl),
            .a    (nm_reg[gk]),
            .b    (nm_reg[gk]),
            .prod (nsq[gk])
        );
        for (genvar gi = 0; gi < 3; gi++)
        begin : g_dot
            pit_mul u_dot (
                .clk  (clk),
                .ctl  (mctl),
                .a    (qm_reg[gi][gk]),
                .b    (nm_reg[gk]),
                .prod (qnp[gi][gk])
            );
        end
    end

    // Carry product signs beside the multipliers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (stage_en[ST_MPP])
                begin
                    tn4_reg[i][k] <= qn_reg[i][k] ^ nn_reg[k];
                end
                if (stage_en[ST_MSUM])
                begin
                    tn5_reg[i][k] <= tn4_reg[i][k];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: n . n, and positive and negative parts of each q . n
    // ---------------------------------------------------------------

    always_comb
    begin
        n2_next = SW'(nsq[0]) + SW'(nsq[1]) + SW'(nsq[2]);
        for (int i = 0; i < 3; i++)
        begin
            ps_next[i] = '0;
            ns_next[i] = '0;
            for (int k = 0; k < 3; k++)
            begin
                if (tn5_reg[i][k])
                begin
                    ns_next[i] = ns_next[i] + SW'(qnp[i][k]);
                end
                else
                begin
                    ps_next[i] = ps_next[i] + SW'(qnp[i][k]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_DOT])
        begin
            n2_reg <= n2_next;
            ps_reg <= ps_next;
            ns_reg <= ns_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 7: edge values as magnitude and sign, degenerate check
    // ---------------------------------------------------------------

    always_comb
    begin
        side7_next.degen = (n2_reg == '0);
        for (int i = 0; i < 3; i++)
        begin
            pmn[i] = ps_reg[i] - ns_reg[i];
            nmp[i] = ns_reg[i] - ps_reg[i];
            side7_next.s_neg[i]  = ps_reg[i] < ns_reg[i];
            side7_next.s_zero[i] = ps_reg[i] == ns_reg[i];
            if (side7_next.s_neg[i])
            begin
                smag_next[i] = nmp[i][WW-1:0];
            end
            else
            begin
                smag_next[i] = pmn[i][WW-1:0];
            end
        end
        n2w_next = n2_reg[WW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_SMAG])
        begin
            smag_reg  <= smag_next;
            n2w_reg   <= n2w_next;
            side7_reg <= side7_next;
        end
    end

    // ---------------------------------------------------------------
    // Stages 8 to 10: squared edge values and squared threshold
    // ---------------------------------------------------------------

    assign wctl.part.pp_en  = stage_en[ST_WPP];
    assign wctl.part.sum_en = stage_en[ST_WMID];
    assign wctl.sum_en      = stage_en[ST_WSUM];

    assign tsq_op = WW'(tol_sq_reg);

    for (genvar gi = 0; gi < 3; gi++)
    begin : g_s2
        pit_wmul u_s2 (
            .clk  (clk),
            .ctl  (wctl),
            .a    (smag_reg[gi]),
            .b    (smag_reg[gi]),
            .prod (s2[gi])
        );
    end

    pit_wmul u_t2 (
        .clk  (clk),
        .ctl  (wctl),
        .a    (tsq_op),
        .b    (n2w_reg),
        .prod (t2)
    );

    // Carry edge signs and the degenerate flag beside the wide products
    always_ff @(posedge clk)
    begin
        if (stage_en[ST_WPP])
        begin
            side8_reg <= side7_reg;
        end
        if (stage_en[ST_WMID])
        begin
            side9_reg <= side8_reg;
        end
        if (stage_en[ST_WSUM])
        begin
            side10_reg <= side9_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 11: edge verdicts and first failing edge
    // ---------------------------------------------------------------

    assign tol_neg = tol_reg[TB-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (tol_neg)
            begin
                bad[i] = side10_reg.s_neg[i] && !(s2[i] < t2);
            end
            else
            begin
                bad[i] = side10_reg.s_neg[i] || side10_reg.s_zero[i] || (s2[i] <= t2);
            end
        end

        if (bad[0])
        begin
            fail_next = pit_pkg::FAIL_E0;
        end
        else if (bad[1])
        begin
            fail_next = pit_pkg::FAIL_E1;
        end
        else if (bad[2])
        begin
            fail_next = pit_pkg::FAIL_E2;
        end
        else
        begin
            fail_next = pit_pkg::FAIL_NONE;
        end

        // Drop the edge verdicts for a zero normal
        degen_next = side10_reg.degen;
        if (degen_next)
        begin
            fail_next = pit_pkg::FAIL_NONE;
        end
        inside_next = !degen_next && (fail_next == pit_pkg::FAIL_NONE);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_OUT])
        begin
            inside_reg <= inside_next;
            fail_reg   <= fail_next;
            degen_reg  <= degen_next;
        end
    end

    assign inside_res   = inside_reg;
    assign failing_edge = fail_reg;
    assign degenerate   = degen_reg;

endmodule

@@ src/pit_checker.sv @@
// Port-level assertions for the point-in-triangle test block, with its bind.
module pit_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       inside_res,
    input logic [1:0] failing_edge,
    input logic       degenerate
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inside_res)
            && $stable(failing_edge) && $stable(degenerate))
        else $error("stalled result changed");

    // A degenerate triangle reports neither inside nor a failing edge
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> !inside_res && (failing_edge == pit_pkg::FAIL_NONE))
        else $error("degenerate result carries edge verdict");

    // Inside exactly when no edge failed
    a_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |-> inside_res == (failing_edge == pit_pkg::FAIL_NONE))
        else $error("inside flag disagrees with failing edge");

    // An empty output stage never blocks a request
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request refused with empty pipeline output");

endmodule

bind point_in_triangle_test_top pit_checker u_pit_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for the point-in-triangle edge test block.
module testbench;

    // Coordinate and tolerance extremes, and a few handy constants
    localparam int CMAX     = (1 << (pit_pkg::COORD_BITS - 1)) - 1;
    localparam int CMIN     = -(1 << (pit_pkg::COORD_BITS - 1));
    localparam int ONE      = 4096;
    localparam int PAT_A    = 'h555555;
    localparam int PAT_B    = -'h555556;
    localparam int TOL_MAX  = (1 << (pit_pkg::TOL_BITS - 1)) - 1;
    localparam int TOL_MIN  = -(1 << (pit_pkg::TOL_BITS - 1));
    localparam logic [pit_pkg::ADDR_W-3:0] REG_SPARE = 1'b1;

    // Run control
    localparam int LATENCY_PAD = 16;
    localparam int LONG_HOLD   = 80;
    localparam int MAX_REPORTS = 10;
    localparam int RUN_LIMIT   = 3_000_000;

    // One request: a, b, c then the point, x/y/z each, lowest index first
    typedef logic [11:0][pit_pkg::COORD_BITS-1:0] tri_req_t;

    // Exact intermediate values, wide enough for every product
    typedef logic signed [255:0] acc_t;

    typedef struct packed {
        logic       in_tri;
        logic [1:0] fail_code;
        logic       degen;
    } verdict_t;

    typedef enum int {SHAPE_BARY, SHAPE_ON_EDGE, SHAPE_DEGEN, SHAPE_NOISE} shape_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Configuration port
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [pit_pkg::ADDR_W-1:0] paddr   = '0;
    logic [pit_pkg::DATA_W-1:0] pwdata  = '0;
    logic [pit_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    // Request channel
    logic                in_valid = 1'b0;
    logic                in_ready;
    pit_pkg::pit_coord_t vert_a_x = '0;
    pit_pkg::pit_coord_t vert_a_y = '0;
    pit_pkg::pit_coord_t vert_a_z = '0;
    pit_pkg::pit_coord_t vert_b_x = '0;
    pit_pkg::pit_coord_t vert_b_y = '0;
    pit_pkg::pit_coord_t vert_b_z = '0;
    pit_pkg::pit_coord_t vert_c_x = '0;
    pit_pkg::pit_coord_t vert_c_y = '0;
    pit_pkg::pit_coord_t vert_c_z = '0;
    pit_pkg::pit_coord_t point_x  = '0;
    pit_pkg::pit_coord_t point_y  = '0;
    pit_pkg::pit_coord_t point_z  = '0;

    // Result channel
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       inside_res;
    logic [1:0] failing_edge;
    logic       degenerate;

    // Tolerance as the block should hold it, and expected verdicts in order
    logic signed [pit_pkg::TOL_BITS-1:0] tol_now = pit_pkg::TOL_RESET;
    verdict_t verdict_q [$];

    // Traffic shaping
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    // Bookkeeping
    int verdict_errs  = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int inside_count  = 0;
    int degen_count   = 0;
    int tol_settings  = 0;

    point_in_triangle_test_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .vert_a_x     (vert_a_x),
        .vert_a_y     (vert_a_y),
        .vert_a_z     (vert_a_z),
        .vert_b_x     (vert_b_x),
        .vert_b_y     (vert_b_y),
        .vert_b_z     (vert_b_z),
        .vert_c_x     (vert_c_x),
        .vert_c_y     (vert_c_y),
        .vert_c_z     (vert_c_z),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .inside_res   (inside_res),
        .failing_edge (failing_edge),
        .degenerate   (degenerate)
    );

    // Free-running clock, period 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // (a x b) . n, exact
    function automatic acc_t cross_dot(input acc_t ax, input acc_t ay, input acc_t az,
                                       input acc_t bx, input acc_t by, input acc_t bz,
                                       input acc_t nx, input acc_t ny, input acc_t nz);
        return (ay * bz - az * by) * nx + (az * bx - ax * bz) * ny + (ax * by - ay * bx) * nz;
    endfunction

    // Expected verdict for one request under tolerance tol
    function automatic verdict_t classify_point(input tri_req_t r,
                                                input logic signed [pit_pkg::TOL_BITS-1:0] tol);
        acc_t     v [4][3];
        acc_t     e [3][3];
        acc_t     ca [3];
        acc_t     n [3];
        acc_t     d [3];
        acc_t     n2, t2, tw, s, s2;
        logic     bad;
        verdict_t res;
        int       i, k;
        for (i = 0; i < 4; i++)
            for (k = 0; k < 3; k++)
                v[i][k] = $signed(r[3 * i + k]);
        for (i = 0; i < 3; i++)
            for (k = 0; k < 3; k++)
                e[i][k] = v[(i + 1) % 3][k] - v[i][k];
        for (k = 0; k < 3; k++)
            ca[k] = v[2][k] - v[0][k];
        // face normal n = e0 x (c - a)
        n[0] = e[0][1] * ca[2] - e[0][2] * ca[1];
        n[1] = e[0][2] * ca[0] - e[0][0] * ca[2];
        n[2] = e[0][0] * ca[1] - e[0][1] * ca[0];
        n2 = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
        res.in_tri    = 1'b0;
        res.fail_code = pit_pkg::FAIL_NONE;
        res.degen     = 1'b0;
        if (n2 == 0)
        begin
            res.degen = 1'b1;
            return res;
        end
        tw = tol;
        t2 = tw * tw * n2;
        // stop at the first edge that fails
        for (i = 0; i < 3 && res.fail_code == pit_pkg::FAIL_NONE; i++)
        begin
            for (k = 0; k < 3; k++)
                d[k] = v[3][k] - v[i][k];
            s  = cross_dot(e[i][0], e[i][1], e[i][2], d[0], d[1], d[2], n[0], n[1], n[2]);
            s2 = s * s;
            if (tol >= 0)
                bad = (s <= 0) || (s2 <= t2);
            else
                bad = (s < 0) && (s2 >= t2);
            if (bad)
                res.fail_code = (i == 0) ? pit_pkg::FAIL_E0
                              : (i == 1) ? pit_pkg::FAIL_E1 : pit_pkg::FAIL_E2;
        end
        res.in_tri = (res.fail_code == pit_pkg::FAIL_NONE);
        return res;
    endfunction

    // Saturate to the coordinate range
    function automatic pit_pkg::pit_coord_t fit_coord(input longint val);
        if (val > CMAX)
            return pit_pkg::pit_coord_t'(CMAX);
        if (val < CMIN)
            return pit_pkg::pit_coord_t'(CMIN);
        return pit_pkg::pit_coord_t'(val);
    endfunction

    // Symmetric random offset: 0 tiny, 1 about one unit, 2 large, 3 full range
    function automatic longint rand_span(input int scale);
        longint h;
        case (scale)
            0:       h = 32;
            1:       h = ONE;
            2:       h = 1 << 20;
            default: h = 1 << (pit_pkg::COORD_BITS - 1);
        endcase
        return longint'($urandom_range(0, 32'(2 * h - 1))) - h;
    endfunction

    function automatic tri_req_t tri_of(input int ax, input int ay, input int az,
                                        input int bx, input int by, input int bz,
                                        input int cx, input int cy, input int cz,
                                        input int px, input int py, input int pz);
        tri_req_t r;
        r[0]  = pit_pkg::pit_coord_t'(ax);
        r[1]  = pit_pkg::pit_coord_t'(ay);
        r[2]  = pit_pkg::pit_coord_t'(az);
        r[3]  = pit_pkg::pit_coord_t'(bx);
        r[4]  = pit_pkg::pit_coord_t'(by);
        r[5]  = pit_pkg::pit_coord_t'(bz);
        r[6]  = pit_pkg::pit_coord_t'(cx);
        r[7]  = pit_pkg::pit_coord_t'(cy);
        r[8]  = pit_pkg::pit_coord_t'(cz);
        r[9]  = pit_pkg::pit_coord_t'(px);
        r[10] = pit_pkg::pit_coord_t'(py);
        r[11] = pit_pkg::pit_coord_t'(pz);
        return r;
    endfunction

    // Random request of a given shape; small triangles sit at a random offset
    function automatic tri_req_t make_request(input shape_t shape, input int scale);
        longint   base [3];
        longint   vx [3][3];
        longint   p [3];
        longint   den, u, w, t;
        int       i, j, k, pick;
        tri_req_t r;
        if (shape == SHAPE_NOISE)
        begin
            for (k = 0; k < 12; k++)
                r[k] = pit_pkg::pit_coord_t'($urandom_range(0,
                                                (1 << pit_pkg::COORD_BITS) - 1));
            return r;
        end
        for (k = 0; k < 3; k++)
            base[k] = (scale < 3) ? rand_span(3) / 2 : 0;
        for (i = 0; i < 3; i++)
            for (k = 0; k < 3; k++)
                vx[i][k] = base[k] + rand_span(scale);
        den  = longint'($urandom_range(1, 16));
        u    = longint'($urandom_range(0, 32'(2 * den))) - den / 2;
        w    = longint'($urandom_range(0, 32'(2 * den))) - den / 2;
        t    = longint'($urandom_range(0, 32'(den)));
        j    = int'($urandom_range(0, 2));
        pick = int'($urandom_range(0, 2));
        for (k = 0; k < 3; k++)
        begin
            case (shape)
                SHAPE_BARY:
                    p[k] = vx[0][k] + ((vx[1][k] - vx[0][k]) * u
                                       + (vx[2][k] - vx[0][k]) * w) / den;
                SHAPE_ON_EDGE:
                    p[k] = vx[j][k] + (vx[(j + 1) % 3][k] - vx[j][k]) * t / den;
                default:
                begin
                    // collapse the triangle: repeated vertex, collinear, or a single point
                    if (pick == 0)
                        vx[1][k] = vx[0][k];
                    else if (pick == 1)
                        vx[2][k] = vx[0][k] + (vx[1][k] - vx[0][k]) * (longint'(j) - 1);
                    else
                    begin
                        vx[1][k] = vx[0][k];
                        vx[2][k] = vx[0][k];
                    end
                    p[k] = base[k] + rand_span(scale);
                end
            endcase
            if (shape != SHAPE_DEGEN && $urandom_range(0, 1) == 1)
                p[k] = p[k] + longint'($urandom_range(0, 40)) - 20;
        end
        for (i = 0; i < 3; i++)
            for (k = 0; k < 3; k++)
                r[3 * i + k] = fit_coord(vx[i][k]);
        for (k = 0; k < 3; k++)
            r[9 + k] = fit_coord(p[k]);
        return r;
    endfunction

    // Offer one request, hold it until accepted, then record its verdict
    task automatic send_request(input tri_req_t r);
        @(negedge clk);
        while (int'($urandom_range(0, 99)) < send_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        {point_z, point_y, point_x, vert_c_z, vert_c_y, vert_c_x,
         vert_b_z, vert_b_y, vert_b_x, vert_a_z, vert_a_y, vert_a_x} = r;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        verdict_q.push_back(classify_point(r, tol_now));
        sent_count++;
    endtask

    task automatic send_random(input int count, input int max_scale);
        int     roll;
        shape_t shape;
        repeat (count)
        begin
            roll = int'($urandom_range(0, 99));
            if (roll < 45)
                shape = SHAPE_BARY;
            else if (roll < 70)
                shape = SHAPE_ON_EDGE;
            else if (roll < 82)
                shape = SHAPE_DEGEN;
            else
                shape = SHAPE_NOISE;
            send_request(make_request(shape, int'($urandom_range(0, max_scale))));
        end
    endtask

    // Drop valid and wait until every request has come back, plus some slack
    task automatic wait_results_done();
        @(negedge clk);
        in_valid = 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    task automatic apb_write(input logic [pit_pkg::ADDR_W-3:0] idx,
                             input logic [pit_pkg::DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == pit_pkg::REG_TOL)
        begin
            tol_now = data[pit_pkg::TOL_BITS-1:0];
            tol_settings++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_tolerance_readback();
        logic [pit_pkg::DATA_W-1:0] rd;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {pit_pkg::REG_TOL, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (rd[pit_pkg::TOL_BITS-1:0] !== tol_now)
        begin
            verdict_errs++;
            if (verdict_errs <= MAX_REPORTS)
                $display("tolerance readback: expected %0d, got %0d",
                         tol_now, $signed(rd[pit_pkg::TOL_BITS-1:0]));
        end
    endtask

    // Write a tolerance with junk in the unused upper bits, then read it back
    task automatic set_tolerance(input int tol);
        logic [pit_pkg::DATA_W-1:0] word;
        word                             = $urandom();
        word[pit_pkg::TOL_BITS-1:0]      = tol[pit_pkg::TOL_BITS-1:0];
        apb_write(pit_pkg::REG_TOL, word);
        check_tolerance_readback();
    endtask

    function automatic int random_tolerance();
        case ($urandom_range(0, 3))
            0:       return int'($urandom_range(0, 512)) - 256;
            1:       return int'($urandom_range(0, (1 << pit_pkg::TOL_BITS) - 1)) + TOL_MIN;
            2:       return int'(pit_pkg::TOL_RESET);
            default: return int'($urandom_range(0, 64));
        endcase
    endfunction

    function automatic int sweep_tolerance(input int step);
        case (step)
            0:       return 0;
            1:       return 1;
            2:       return -1;
            3:       return 168;
            4:       return TOL_MAX;
            5:       return TOL_MIN;
            default: return 2500;
        endcase
    endfunction

    // Reset value, then a write to an unmapped index that must change nothing
    task automatic test_register_access();
        check_tolerance_readback();
        apb_write(REG_SPARE, $urandom());
        check_tolerance_readback();
    endtask

    // Hand-picked triangles at the reset tolerance
    task automatic test_directed_cases();
        send_gap_pct   = 10;
        recv_stall_pct = 10;
        // unit right triangle: inside, then outside each edge in turn
        send_request(tri_of(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1000, 1000, 0));
        send_request(tri_of(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1000, -1000, 0));
        send_request(tri_of(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 3000, 3000, 0));
        send_request(tri_of(0, 0, 0, ONE, 0, 0, 0, ONE, 0, -1000, 1000, 0));
        // on a vertex, on an edge, and far off the plane
        send_request(tri_of(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, 0));
        send_request(tri_of(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 2048, 2048, 0));
        send_request(tri_of(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1000, 1000, CMAX));
        // degenerate: all zero, collinear, repeated vertex
        send_request(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(tri_of(0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 5, 5, 5));
        send_request(tri_of(5, 5, 5, 5, 5, 5, 100, 0, 0, 50, 1, 0));
        // reversed winding, point inside
        send_request(tri_of(0, 0, 0, 0, ONE, 0, ONE, 0, 0, 1000, 1000, 0));
        // tiny triangle: slightly outside is let through by the negative tolerance
        send_request(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, -1, 0));
        send_request(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, -200, 0));
        send_request(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, -168, 0));
        send_request(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, -167, 0));
        // coordinate extremes
        send_request(tri_of(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX,
                            CMIN, CMAX, 0));
        send_request(tri_of(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX,
                            CMAX, CMAX, CMAX));
        send_request(tri_of(CMIN, CMAX, 0, CMAX, CMAX, CMIN, 0, CMIN, CMAX, 0, 0, 0));
        send_request(tri_of(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                            CMAX, CMAX, CMAX));
        send_request(tri_of(CMIN, CMIN, 0, CMAX, CMIN, 0, 0, CMAX, 0, 0, 0, CMIN));
        // alternating bit patterns
        send_request(tri_of(PAT_A, PAT_B, PAT_A, PAT_B, PAT_A, PAT_B, PAT_A, PAT_A, PAT_B,
                            PAT_B, PAT_B, PAT_A));
        wait_results_done();
    endtask

    // Small triangles near their edges under a range of tolerances
    task automatic test_tolerance_sweep();
        int step;
        send_gap_pct   = 20;
        recv_stall_pct = 20;
        for (step = 0; step < 7; step++)
        begin
            set_tolerance(sweep_tolerance(step));
            send_random(30, 1);
            wait_results_done();
        end
    endtask

    // Hold the result side off long enough that the pipeline backs up
    task automatic test_backpressure();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        set_tolerance(int'(pit_pkg::TOL_RESET));
        @(posedge clk);
        hold_left = LONG_HOLD;
        send_random(40, 3);
        wait_results_done();
    endtask

    // Three phases of random traffic with different idle patterns
    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 3; phase++)
        begin
            set_tolerance(random_tolerance());
            send_gap_pct   = (phase == 0) ? 24 : (phase == 1) ? 75 : 0;
            recv_stall_pct = (phase == 0) ? 75 : (phase == 1) ? 24 : 0;
            send_random(210, 3);
            wait_results_done();
        end
    endtask

    // Result side: random stalls, or a counted hold-off when one is requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = (int'($urandom_range(0, 99)) >= recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expected verdict
    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                verdict_errs++;
                if (verdict_errs <= MAX_REPORTS)
                    $display("unexpected result: in=%0b fail=%0d degen=%0b",
                             inside_res, failing_edge, degenerate);
            end
            else
            begin
                want = verdict_q.pop_front();
                checked_count++;
                if (want.in_tri)
                    inside_count++;
                if (want.degen)
                    degen_count++;
                if (inside_res !== want.in_tri || failing_edge !== want.fail_code
                    || degenerate !== want.degen)
                begin
                    verdict_errs++;
                    if (verdict_errs <= MAX_REPORTS)
                        $display("result %0d: exp %0b/%0d/%0b, got %0b/%0d/%0b (in/fail/degen)",
                                 checked_count, want.in_tri, want.fail_code, want.degen,
                                 inside_res, failing_edge, degenerate);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #RUN_LIMIT;
        $display("Regression FAIL");
        $finish;
    end

    // Test sequence
    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        test_register_access();
        test_directed_cases();
        test_tolerance_sweep();
        test_backpressure();
        test_random_traffic();
        wait_results_done();
        $display("Checked %0d of %0d requests: %0d inside, %0d degenerate.",
                 checked_count, sent_count, inside_count, degen_count);
        $display("Tolerance written %0d times; %0d mismatches.", tol_settings, verdict_errs);
        if (verdict_errs == 0 && verdict_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
src/pit_pkg.sv
src/pit_mul.sv
src/pit_wmul.sv
src/point_in_triangle_test_top.sv
src/pit_checker.sv
sim/testbench.sv
